@@ rtl/core/mavg_pkg.sv @@
// Package for the moving average window block: shared widths, defaults and
// the command/status structs between controller and datapath. No dependencies.
package mavg_pkg;

  localparam int DATA_W         = 16;  // sample and average width
  localparam int LEN_W          = 7;   // window length register width
  localparam int MAX_WINDOW_DEF = 64;  // default store depth
  localparam int WIN_RESET      = 64;  // window length after reset

  // controller -> datapath
  typedef struct packed {
    logic accept;    // capture sample, read old entry
    logic update;    // update running sum, write store, start divide
    logic div_step;  // one quotient bit
    logic load_out;  // move quotient into the output register
  } mavg_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_last;  // current divide step is the final one
    logic out_free;  // output register can take a word this cycle
  } mavg_sts_t;

endpackage

@@ rtl/core/mavg_ctrl.sv @@
// Sequencer for the moving average window: accept, update, divide, output.
// Depends on mavg_pkg for the command and status structs.
module mavg_ctrl
  import mavg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mavg_sts_t sts_i,
  output mavg_cmd_t cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StUpdate = 2'd1;
  localparam logic [1:0] StDiv    = 2'd2;
  localparam logic [1:0] StFin    = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StFin;
      end
      StFin: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/mavg_dp.sv @@
// Datapath of the moving average window: sample store, running sum,
// bit-serial divider and output register. Depends on mavg_pkg.
module mavg_dp
  import mavg_pkg::*;
#(
  parameter int MaxWindow = MAX_WINDOW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LEN_W-1:0]  cfg_wdata_i,
  input  logic [DATA_W-1:0] sample_i,
  input  mavg_cmd_t         cmd_i,
  output mavg_sts_t         sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o
);

  localparam int IDX_W = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int SUM_W = DATA_W + IDX_W;
  localparam int REM_W = LEN_W + 1;
  localparam int CNT_W = $clog2(SUM_W + 1);

  // sample store; entries not yet written since the last clear read as zero
  logic [DATA_W-1:0]    mem [MaxWindow];
  logic [DATA_W-1:0]    rd_data_q;
  logic [MaxWindow-1:0] vld_q;
  logic                 old_vld_q;

  logic [LEN_W-1:0]        len_q, len_d;
  logic [IDX_W-1:0]        pos_q, pos_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [DATA_W-1:0]       sample_q;

  logic [SUM_W-1:0] quo_q;
  logic [REM_W-1:0] rem_q, rem_sh;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic             qbit;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;

  logic signed [SUM_W-1:0] old_ext;
  logic signed [SUM_W-1:0] new_ext;

  // window length write: zero maps to one, large values saturate
  always_comb begin
    len_d = cfg_wdata_i;
    if (cfg_wdata_i == '0) len_d = LEN_W'(1);
    else if (int'(cfg_wdata_i) > MaxWindow) len_d = LEN_W'(MaxWindow);
  end

  assign old_ext = old_vld_q ? SUM_W'($signed(rd_data_q)) : '0;
  assign new_ext = SUM_W'($signed(sample_q));
  assign sum_d   = sum_q - old_ext + new_ext;

  assign pos_d = ((int'(pos_q) + 1) >= int'(len_q)) ? '0 : pos_q + IDX_W'(1);

  // restoring divide on the magnitude, one bit per cycle
  assign rem_sh = {rem_q[REM_W-2:0], quo_q[SUM_W-1]};
  assign qbit   = (rem_sh >= {1'b0, len_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) mem[pos_q] <= sample_q;
    if (cmd_i.accept) rd_data_q <= mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) sample_q <= sample_i;
    if (cmd_i.update) begin
      quo_q <= sum_d[SUM_W-1] ? SUM_W'(-sum_d) : SUM_W'(sum_d);
      neg_q <= sum_d[SUM_W-1];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], qbit};
      rem_q <= qbit ? (rem_sh - {1'b0, len_q}) : rem_sh;
    end
    if (cmd_i.load_out) begin
      out_data_q <= neg_q ? DATA_W'(-quo_q[DATA_W-1:0]) : quo_q[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= LEN_W'((WIN_RESET > MaxWindow) ? MaxWindow : WIN_RESET);
      pos_q       <= '0;
      sum_q       <= '0;
      vld_q       <= '0;
      old_vld_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= len_d;
        pos_q <= '0;
        sum_q <= '0;
        vld_q <= '0;
      end else if (cmd_i.update) begin
        pos_q        <= pos_d;
        sum_q        <= sum_d;
        vld_q[pos_q] <= 1'b1;
      end
      if (cmd_i.accept) old_vld_q <= vld_q[pos_q];
      if (cmd_i.update) cnt_q <= '0;
      else if (cmd_i.div_step) cnt_q <= cnt_q + CNT_W'(1);
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.div_last = (cnt_q == CNT_W'(SUM_W - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

endmodule

@@ rtl/core/moving_average_window.sv @@
// Top level of the moving average window: boxcar average over 1..MaxWindow
// samples. Instantiates mavg_ctrl and mavg_dp; uses mavg_pkg.
//
// Usage:
//   Input words arrive on s_axis (tdata = signed 16-bit sample). Each word
//   yields exactly one output word on m_axis (tdata = signed 16-bit average
//   of the last window_length samples, truncated toward zero).
//   cfg_we_i/cfg_wdata_i write the window length (1..MaxWindow, zero reads
//   as one, larger values saturate). A write also clears the sample store,
//   the write position and the running sum. Write only while idle.
// Timing:
//   Accept edge, an update step, then the divide steps (one quotient bit
//   per cycle in the restoring divider over SUM_W = 16 + log2(MaxWindow)
//   bits, 22 by default), then a step that loads the output register.
//   A new input word is taken only after the previous average has been
//   loaded into the output register.
// Reset: window length min(64, MaxWindow), store reads as zero, sum zero.
// Stall: a finished average waits in the output register while the next
//   input word is taken and processed; the block holds in its last step
//   only if a second result is ready before the first is taken.
module moving_average_window
  import mavg_pkg::*;
#(
  parameter int MaxWindow = MAX_WINDOW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [LEN_W-1:0]  cfg_wdata_i,    // window_length
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // [15:0] sample
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata    // [15:0] average
);

  mavg_cmd_t cmd;
  mavg_sts_t sts;

  mavg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mavg_dp #(
    .MaxWindow (MaxWindow)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

@@ bench/mavg_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for moving_average_window: watches the config write and both
// streams, keeps its own window model and compares each output word. Uses mavg_pkg.
module mavg_checker
  import mavg_pkg::*;
#(
  parameter int MaxWindow = MAX_WINDOW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LEN_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [DATA_W-1:0] in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [DATA_W-1:0] out_data_i,
  output int                err_count_o,
  output int                pending_o
);

  localparam int SUM_W    = DATA_W + $clog2(MaxWindow);
  localparam int MAX_SHOW = 10;

  typedef logic signed [DATA_W-1:0] sample_t;

  sample_t                 win_store [MaxWindow];
  logic signed [SUM_W-1:0] win_sum;
  int unsigned             win_pos;
  int unsigned             win_len;
  sample_t                 avg_q [$];
  int                      errs;

  function automatic void clear_window();
    for (int i = 0; i < MaxWindow; i++) win_store[i] = '0;
    win_pos = 0;
    win_sum = '0;
  endfunction

  // push one sample through the ring, return the truncated average
  function automatic sample_t slide_window(input sample_t s);
    int quo;
    if (win_pos >= win_len) win_pos = 0;
    win_sum = win_sum - win_store[win_pos] + s;
    win_store[win_pos] = s;
    win_pos = (win_pos + 1 >= win_len) ? 0 : win_pos + 1;
    quo = int'(win_sum) / int'(win_len);
    return sample_t'(quo);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t want;
    if (!rst_ni) begin
      clear_window();
      win_len = (WIN_RESET > MaxWindow) ? MaxWindow : WIN_RESET;
      avg_q.delete();
      errs = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (avg_q.size() == 0) begin
          errs++;
          if (errs <= MAX_SHOW)
            $display("%0t: unexpected average word %0d", $time, $signed(out_data_i));
        end else begin
          want = avg_q.pop_front();
          if (sample_t'(out_data_i) !== want) begin
            errs++;
            if (errs <= MAX_SHOW)
              $display("%0t: average mismatch: expected %0d, got %0d",
                       $time, want, $signed(out_data_i));
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_wdata_i == 0) win_len = 1;
        else if (cfg_wdata_i > MaxWindow) win_len = MaxWindow;
        else win_len = cfg_wdata_i;
        clear_window();
      end
      if (in_valid_i && in_ready_i)
        avg_q.push_back(slide_window(sample_t'(in_data_i)));
      err_count_o <= errs;
      pending_o   <= avg_q.size();
    end
  end

endmodule

@@ bench/tb_moving_average_window.sv @@
`timescale 1ns / 100ps
// Testbench top for moving_average_window: drives samples and window lengths,
// varies back-pressure per phase, verdict from mavg_checker. Uses mavg_pkg.
module tb_moving_average_window;
  import mavg_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RST_CYCLES = 11;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_LEN  = 85;         // words per random phase
  localparam int SETTLE     = 30;         // longer than one word takes to process
  localparam int LIMIT      = 1000000;    // cycle budget for the whole run
  localparam int IDLE_PCT   = 66;
  localparam int BOTH_PCT   = 7;

  typedef logic signed [DATA_W-1:0] sample_t;

  localparam sample_t MAX_POS = 16'sh7fff;
  localparam sample_t MAX_NEG = 16'sh8000;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [LEN_W-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b1;
  logic [DATA_W-1:0] m_axis_tdata;

  int err_count;
  int pending;
  int cycle_cnt = 0;

  // sender gap and receiver stall odds, in percent
  int gap_pct   = 0;
  int stall_pct = 0;
  int hold_left = 0;

  // runs of one extreme value; a phase-opening run fills a whole window
  int      run_left = 0;
  sample_t run_val  = '0;

  // window setting per random phase: extremes, zero and out-of-range codes
  logic [LEN_W-1:0] phase_window [NUM_PHASES] =
    '{7'd64, 7'd1, 7'd127, 7'd2, 7'd0, 7'd63, 7'd64, 7'd3, 7'd100, 7'd17, 7'd64, 7'd33};

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  moving_average_window u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mavg_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random per-cycle stalls plus the odd long hold, so a finished
  // average can sit in the output register across a whole divide
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 199) == 0) begin
      hold_left     <= $urandom_range(10, 60);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // offer one word; returns at the edge it was taken, tvalid still high so
  // back-to-back words need no bubble
  task automatic push_sample(input sample_t s);
    int idle_cycles;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      // mostly short gaps, sometimes long enough to straddle a whole divide
      idle_cycles = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40)
                                                : $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (idle_cycles) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop sending and wait for every average to come back, then let the
  // block settle; pending is registered, hence the first wait
  task automatic drain_averages();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [LEN_W-1:0] len);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    if (run_left != 0) begin
      run_left--;
      return run_val;
    end
    if ($urandom_range(0, 19) == 0) begin
      run_left = $urandom_range(0, 40);
      run_val  = $urandom_range(0, 1) ? MAX_POS : MAX_NEG;
      return run_val;
    end
    case ($urandom_range(0, 4))
      0:       return sample_t'(int'($urandom_range(0, 8)) - 4);  // sign of truncation
      1:       return $urandom_range(0, 1) ? MAX_POS : MAX_NEG;
      default: return sample_t'($urandom());
    endcase
  endfunction

  initial begin
    int eff;

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset window of 64 with zero-filled store
    push_sample(MAX_POS);
    push_sample(MAX_NEG);
    push_sample(-16'sd1);
    push_sample(16'sd1);
    drain_averages();

    // zero length reads as one: output follows input
    set_window('0);
    push_sample(MAX_NEG);
    push_sample(MAX_POS);
    push_sample('0);
    drain_averages();

    // all-ones code saturates to the full window
    set_window('1);
    push_sample(MAX_NEG);
    push_sample(MAX_NEG);
    drain_averages();

    // even window: -1/2 truncates to zero, extremes sum without overflow
    set_window(7'd2);
    push_sample(-16'sd1);
    push_sample('0);
    push_sample(MAX_POS);
    push_sample(MAX_POS);
    push_sample(MAX_NEG);
    push_sample(MAX_NEG);
    push_sample(16'sh5555);
    drain_averages();

    // odd window, negative remainders
    set_window(7'd3);
    push_sample(-16'sd1);
    push_sample(-16'sd1);
    push_sample(MAX_NEG);
    push_sample(MAX_NEG);
    push_sample(MAX_NEG);
    push_sample(MAX_POS);
    drain_averages();

    // random phases, each with its own window and back-pressure profile
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_window(phase_window[ph]);
      case (ph % 4)
        0: begin gap_pct = 0;        stall_pct <= 0;        end
        1: begin gap_pct = IDLE_PCT; stall_pct <= 0;        end
        2: begin gap_pct = 0;        stall_pct <= IDLE_PCT; end
        default: begin gap_pct = BOTH_PCT; stall_pct <= BOTH_PCT; end
      endcase
      eff = (phase_window[ph] == 0) ? 1 :
            (phase_window[ph] > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : phase_window[ph];
      // half the phases open with a run that fills the window with one extreme
      if ($urandom_range(0, 1)) begin
        run_left = $urandom_range(eff, eff + 10);
        run_val  = $urandom_range(0, 1) ? MAX_POS : MAX_NEG;
      end else begin
        run_left = 0;
      end
      for (int k = 0; k < PHASE_LEN; k++) begin
        // mid-phase pause until the output side has fully caught up
        if (ph % 3 == 1 && k == PHASE_LEN / 2) drain_averages();
        push_sample(pick_sample());
      end
      drain_averages();
    end

    gap_pct = 0;
    stall_pct <= 0;
    drain_averages();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
